// ===== design/avs_pkg.sv =====
// Shared types for the ascending value sorter: controller commands and datapath status.
`timescale 1ns / 1ps

package avs_pkg;

	// Width of one element and of the signed values in flight
	localparam int unsigned VALUE_W = 32;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // insert the accepted word (or drop it when full)
		logic pop;    // remove the head word, which has just been taken
	} avs_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic one_left;   // exactly one word is still held
	} avs_sts_t;

endpackage : avs_pkg

// ===== design/ascending_value_sorter_core.sv =====
// Top level of the ascending value sorter: controller and insertion-cell datapath.
`timescale 1ns / 1ps

// The sorter takes a run of signed 32-bit words, one per input handshake, with
// the final word of the run marked by last. Each word is inserted into a sorted
// row of MAX_ELEMENTS registers as it arrives; words that arrive once the row is
// full are dropped, and every result of that run then carries the overflow flag.
// After the final word the block stops taking input and returns the held words
// in ascending order, one result word per cycle while res_ready is high, with
// last_res on the final one. The single insertion row takes one word per cycle
// while loading and shifts out one word per cycle from its head while res_ready
// is high. Input is taken again in the cycle after the final result word is
// accepted. There is no clearing pass after reset: only cells below the fill
// count are ever read.
module ascending_value_sorter_core #(
	parameter int unsigned MAX_ELEMENTS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic signed [avs_pkg::VALUE_W-1:0] value,
	input  logic                               last,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [avs_pkg::VALUE_W-1:0] value_res,
	output logic                               last_res,
	output logic                               overflow
);

	// Command and status between the state machine and the cell row.
	avs_pkg::avs_cmd_t cmd;
	avs_pkg::avs_sts_t sts;

	// The controller decides when a word is loaded and when the head word leaves.
	avs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.last       (last),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// The datapath keeps the words sorted, so the smallest always sits at the head.
	avs_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.value_res (value_res),
		.last_res  (last_res),
		.overflow  (overflow)
	);

endmodule : ascending_value_sorter_core

// ===== design/avs_ctrl.sv =====
// Controller state machine of the ascending value sorter: load phase and emit phase.
`timescale 1ns / 1ps

module avs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              last,
	output logic              res_valid,
	input  logic              res_ready,
	output avs_pkg::avs_cmd_t cmd,
	input  avs_pkg::avs_sts_t sts
);

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	logic in_take;
	logic out_take;

	assign item_ready = (state_q == ST_LOAD);
	assign res_valid  = (state_q == ST_EMIT);
	assign in_take    = item_valid && item_ready;
	assign out_take   = res_valid && res_ready;

	assign cmd.load = in_take;
	assign cmd.pop  = out_take;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_take && last) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_take && sts.one_left) begin
					state_nxt = ST_LOAD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule : avs_ctrl

// ===== design/avs_dp.sv =====
// Datapath of the ascending value sorter: a sorted row of insertion cells with a shift-out head.
`timescale 1ns / 1ps

module avs_dp #(
	parameter int unsigned MAX_ELEMENTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  avs_pkg::avs_cmd_t                   cmd,
	output avs_pkg::avs_sts_t                   sts,
	input  logic signed [avs_pkg::VALUE_W-1:0]  value,
	output logic signed [avs_pkg::VALUE_W-1:0]  value_res,
	output logic                                last_res,
	output logic                                overflow
);

	localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

	logic signed [avs_pkg::VALUE_W-1:0] cell_q   [MAX_ELEMENTS];
	logic signed [avs_pkg::VALUE_W-1:0] cell_ins [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0]            shift;
	logic [CNT_W-1:0]                   count_q;
	logic                               ovf_q;
	logic                               full;

	assign full = (count_q == CNT_W'(MAX_ELEMENTS));

	// Held cells above the new word move up one place; the row stays sorted.
	always_comb begin
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			shift[i] = (CNT_W'(i) < count_q) && (cell_q[i] > value);
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
			if (g == 0) begin : g_head
				always_comb begin
					cell_ins[g] = (shift[g] || (count_q == CNT_W'(g))) ? value : cell_q[g];
				end
			end else begin : g_body
				always_comb begin
					if (shift[g-1]) begin
						cell_ins[g] = cell_q[g-1];
					end else if (shift[g] || (count_q == CNT_W'(g))) begin
						cell_ins[g] = value;
					end else begin
						cell_ins[g] = cell_q[g];
					end
				end
			end

			if (g == MAX_ELEMENTS - 1) begin : g_top
				always_ff @(posedge clk) begin
					if (cmd.load && !full) begin
						cell_q[g] <= cell_ins[g];
					end
				end
			end else begin : g_mid
				always_ff @(posedge clk) begin
					if (cmd.load && !full) begin
						cell_q[g] <= cell_ins[g];
					end else if (cmd.pop) begin
						cell_q[g] <= cell_q[g+1];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					ovf_q <= 1'b0;
				end
			end
		end
	end

	assign sts.one_left = (count_q == CNT_W'(1));
	assign value_res    = cell_q[0];
	assign last_res     = sts.one_left;
	assign overflow     = ovf_q;

endmodule : avs_dp

// ===== design/avs_checker.sv =====
// Port-level checks for the ascending value sorter, bound to its top level.
`timescale 1ns / 1ps

module avs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic                               last,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic signed [avs_pkg::VALUE_W-1:0] value_res,
	input logic                               last_res,
	input logic                               overflow
);

	// Loading and draining never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && item_ready))
		else $error("input taken while results are offered");

	// The final word of a run starts the drain at once.
	a_drain_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && last) |=> res_valid)
		else $error("no result after the final word of a run");

	// Results come out in ascending order.
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && !last_res) |=>
		(res_valid && (value_res >= $past(value_res))))
		else $error("results out of ascending order");

	// The overflow flag is the same on every result of a run.
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && !last_res) |=> $stable(overflow))
		else $error("overflow flag changed within a run");

	// After the final result the block returns to loading.
	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && last_res) |=> (!res_valid && item_ready))
		else $error("results continue after the final one");

endmodule : avs_checker

bind ascending_value_sorter_core avs_checker u_avs_checker (.*);

// ===== verif/ascending_value_sorter_core_tb.sv =====
// Self-checking testbench for the ascending value sorter core.
`timescale 1ns / 1ps

// The bench feeds runs of signed words into the sorter and checks every sorted
// word that comes back. Each run ends on a word marked by last. The bench keeps
// its own copy of the words held for the current run, together with a flag that
// records whether any word was dropped for lack of room. When the final word of
// a run is accepted, that copy is sorted and the expected result words are
// queued. A short table of directed words comes first. It covers both ends of
// the signed range, zero and minus one, duplicates, and words with alternating
// bit patterns. One-word runs there carry their expected result typed in.
// Random runs follow. They have mixed lengths, including exact fills of the
// store and runs that overflow it, and their values come from narrow,
// extreme-heavy and full-range mixes. Both sides idle in random bursts. Early
// in the random part the receiver also holds off for a long stretch, so that
// the sorter has to hold its results and stall its input.
module ascending_value_sorter_core_tb;

	localparam int          W            = avs_pkg::VALUE_W;
	localparam int unsigned CAPACITY     = 16;
	localparam int unsigned RANDOM_WORDS = 350;
	localparam int unsigned QUIET_WORDS  = 60;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_GRACE  = 3 * CAPACITY;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// The value styles that a random run draws its words from.
	typedef enum int {
		STYLE_NARROW,   // a handful of values near zero, so duplicates are common
		STYLE_EXTREME,  // mostly the ends of the range, zero and minus one
		STYLE_FULL      // any 32-bit pattern
	} value_style_t;

	// One result word as the sorter should produce it.
	typedef struct {
		logic signed [W-1:0] v;
		bit                  fin;
		bit                  ovf;
	} sorted_word_t;

	// One row of the directed table. Where typed is set, the row is a run of one
	// word, and the expected result is given in the row rather than predicted.
	typedef struct {
		logic signed [W-1:0] v;
		bit                  fin;
		bit                  typed;
		logic signed [W-1:0] typed_v;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 16;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff},
		'{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
		'{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
		'{32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
		'{32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{32'hffff_ffff, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0001, 1'b1, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{32'h0000_0007, 1'b0, 1'b0, 32'h0},
		'{32'hffff_fff9, 1'b1, 1'b0, 32'h0},
		'{32'h8000_0001, 1'b0, 1'b0, 32'h0},
		'{32'h7fff_fffe, 1'b0, 1'b0, 32'h0},
		'{32'h5555_5555, 1'b0, 1'b0, 32'h0},
		'{32'haaaa_aaaa, 1'b1, 1'b0, 32'h0}
	};

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	logic signed [W-1:0] value;
	logic                last;
	logic                res_valid;
	logic                res_ready;
	logic signed [W-1:0] value_res;
	logic                last_res;
	logic                overflow;

	// Prediction state: the words held for the current run and the drop flag.
	logic signed [W-1:0] held_words [$];
	bit                  words_dropped = 1'b0;
	sorted_word_t        sorted_due [$];

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          hold_wanted    = 1'b0;   // asks the receiver for its long hold-off
	bit          quiet          = 1'b0;   // no idling on either side from here on

	ascending_value_sorter_core #(
		.MAX_ELEMENTS(CAPACITY)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.value     (value),
		.last      (last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.value_res (value_res),
		.last_res  (last_res),
		.overflow  (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// Takes in one accepted word. A word arriving when the store is already full
	// is dropped and marks the run as overflowed. On the final word, the held
	// words are sorted by insertion and, where asked, queued as expected results.
	// The run state then clears, whether or not the results were queued.
	function automatic void absorb_word(input logic signed [W-1:0] v, input bit fin,
			input bit publish);
		logic signed [W-1:0] ordered [$];
		logic signed [W-1:0] key;
		int                  j;
		if (held_words.size() < CAPACITY)
			held_words.push_back(v);
		else
			words_dropped = 1'b1;
		if (fin) begin
			ordered = held_words;
			for (int i = 1; i < ordered.size(); i++) begin
				key = ordered[i];
				j = i - 1;
				while (j >= 0 && ordered[j] > key) begin
					ordered[j + 1] = ordered[j];
					j--;
				end
				ordered[j + 1] = key;
			end
			if (publish)
				foreach (ordered[i])
					sorted_due.push_back('{ordered[i], i == ordered.size() - 1, words_dropped});
			held_words.delete();
			words_dropped = 1'b0;
		end
	endfunction

	function automatic logic signed [W-1:0] pick_value(input value_style_t style);
		case (style)
			STYLE_NARROW: return int'($urandom_range(0, 8)) - 4;
			STYLE_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					3: return 32'hffff_ffff;
					default: return $urandom();
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	// Offers one word from a falling edge and holds it until the rising edge at
	// which it is taken. The task returns on the following falling edge, so the
	// next word can be presented without valid ever dropping.
	task automatic put_word(input logic signed [W-1:0] v, input bit fin, input bit typed,
			input logic signed [W-1:0] typed_v);
		item_valid <= 1'b1;
		value      <= v;
		last       <= fin;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		absorb_word(v, fin, !typed);
		if (typed)
			sorted_due.push_back('{typed_v, 1'b1, 1'b0});
		@(negedge clk);
	endtask

	// Now and then the sender pauses for a burst of idle cycles.
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 19))
				@(negedge clk);
		end
	endtask

	// Receiver: ready changes only at falling edges. Idle bursts are random,
	// apart from one long hold-off that is counted out here, and ready stays high
	// throughout the quiet tail of the run.
	initial begin
		int unsigned pause;
		pause = 0;
		res_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_wanted) begin
				res_ready <= 1'b0;
				repeat (LONG_HOLD)
					@(negedge clk);
				hold_wanted = 1'b0;
			end else if (quiet) begin
				res_ready <= 1'b1;
			end else if (pause > 0) begin
				res_ready <= 1'b0;
				pause--;
			end else if ($urandom_range(0, 9) == 0) begin
				res_ready <= 1'b0;
				pause = $urandom_range(1, 19) - 1;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// Every accepted result word is checked against the oldest expectation.
	always @(posedge clk) begin : watch_results
		sorted_word_t due;
		if (arst_n && res_valid && res_ready) begin
			if (sorted_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result word %0d", value_res));
			end else begin
				due = sorted_due.pop_front();
				if (value_res !== due.v)
					flag_mismatch($sformatf("value_res %0d, expected %0d", value_res, due.v));
				if (last_res !== due.fin)
					flag_mismatch($sformatf("last_res %b, expected %b", last_res, due.fin));
				if (overflow !== due.ovf)
					flag_mismatch($sformatf("overflow %b, expected %b", overflow, due.ovf));
			end
		end
	end

	// The run is bounded by a cycle count, well beyond the slowest correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ascending_value_sorter_core regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned  sent;
		int unsigned  run_len;
		value_style_t style;
		bit           steady;
		item_valid <= 1'b0;
		value      <= '0;
		last       <= 1'b0;
		arst_n     <= 1'b0;
		// Reset is held from time zero and released at a falling edge.
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			put_word(directed_rows[r].v, directed_rows[r].fin, directed_rows[r].typed,
				directed_rows[r].typed_v);
			sender_gap();
		end

		// The receiver's long hold-off starts with the random part, while
		// runs are still being offered at full tilt.
		hold_wanted = 1'b1;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0:       run_len = CAPACITY;
				1, 2:    run_len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
				3:       run_len = 1;
				default: run_len = $urandom_range(2, CAPACITY - 1);
			endcase
			style  = value_style_t'($urandom_range(STYLE_NARROW, STYLE_FULL));
			steady = ($urandom_range(0, 2) == 0);
			quiet  = (sent + QUIET_WORDS >= RANDOM_WORDS);
			for (int unsigned k = 1; k <= run_len; k++) begin
				put_word(pick_value(style), k == run_len, 1'b0, '0);
				sent++;
				if (!steady)
					sender_gap();
			end
		end
		item_valid <= 1'b0;

		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GRACE)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("ascending_value_sorter_core regression: pass");
		else
			$display("ascending_value_sorter_core regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/avs_pkg.sv
design/avs_ctrl.sv
design/avs_dp.sv
design/ascending_value_sorter_core.sv
design/avs_checker.sv
verif/ascending_value_sorter_core_tb.sv
